### src/ifp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ifp_pkg;

	localparam int MaxLength = 4096;
	localparam int PosWidth  = $clog2(MaxLength + 1);
	localparam int NumWords  = 6;
	localparam int WordMax   = 9;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PREFIX,
		PH_PAREN,
		PH_FIRST,
		PH_GAP,
		PH_MATCH,
		PH_CUSTOM
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FLAGS = 2'd1,
		ST_NO_PAREN  = 2'd2,
		ST_UNTERM    = 2'd3
	} status_t;

	localparam logic [7:0] WordText [NumWords][WordMax] = '{
		'{"\\", "d", "e", "l", "e", "t", "e", "d", 8'h00},
		'{"\\", "f", "l", "a", "g", "g", "e", "d", 8'h00},
		'{"\\", "a", "n", "s", "w", "e", "r", "e", "d"},
		'{"\\", "s", "e", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"\\", "r", "e", "c", "e", "n", "t", 8'h00, 8'h00},
		'{"o", "l", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] WordLen [NumWords] = '{4'd8, 4'd8, 4'd9, 4'd5, 4'd7, 4'd3};

	localparam logic [4:0] WordFlag [NumWords] = '{
		5'b00001, 5'b00010, 5'b00100, 5'b01000, 5'b00000, 5'b10000
	};

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == " ") || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] head_char(input logic [2:0] off);
		logic [7:0] r;
		unique case (off)
			3'd0: r = "f";
			3'd1: r = "l";
			3'd2: r = "a";
			3'd3: r = "g";
			3'd4: r = "s";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] word_char(input int unsigned w, input logic [3:0] off);
		logic [7:0] r;
		r = 8'h00;
		if (off < 4'(WordMax)) begin
			r = WordText[w][off];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### src/imap_flags_list_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Parses one IMAP FLAGS response, one byte per beat, and returns one result beat per
// string: a status, the five flag bits, a saturating count of custom keywords and the
// length through the closing parenthesis. A byte with starts_string set opens a new
// string and drops any string still in progress; a zero byte ends the string. Bytes
// taken after a result and before the next start are ignored. One byte is accepted
// every cycle while in_stall is low; the byte that completes a string passes through
// the input register and the single parse step, and its result beat is held in the result register.
module imap_flags_list_parser (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire                         starts_string,
	input  wire  [7:0]                  text_byte,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [1:0]                  status,
	output logic                        deleted_flag,
	output logic                        flagged_flag,
	output logic                        answered_flag,
	output logic                        seen_flag,
	output logic                        old_flag,
	output logic [7:0]                  keyword_count,
	output logic [ifp_pkg::PosWidth-1:0] consumed_length
);
	import ifp_pkg::*;

	logic                valid_s1;
	logic                start_s1;
	logic [7:0]          byte_s1;

	phase_t              phase_q, phase_d;
	logic [3:0]          off_q, off_d;
	logic [NumWords-1:0] mask_q, mask_d;
	logic [4:0]          flags_q, flags_d;
	logic [7:0]          count_q, count_d;
	logic [PosWidth-1:0] pos_q, pos_d;

	logic                emit;
	status_t             st;
	logic                can_proc;
	logic                step;
	logic [7:0]          lc;
	logic [NumWords-1:0] next_m;
	logic [NumWords-1:0] first_m;
	logic [4:0]          done_flags;
	logic                done_any;
	logic                tok_start;
	logic                bump;
	logic                go_custom;

	logic                out_valid_q;
	status_t             status_q;
	logic [4:0]          flags_out_q;
	logic [7:0]          count_out_q;
	logic [PosWidth-1:0] len_out_q;

	assign can_proc = !out_valid_q || !out_stall;
	assign step     = valid_s1 && can_proc;
	assign in_stall = valid_s1 && !can_proc;
	assign lc       = to_lower(byte_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			start_s1 <= starts_string;
			byte_s1  <= text_byte;
		end
	end

	always_comb begin
		next_m     = '0;
		first_m    = '0;
		done_flags = '0;
		for (int i = 0; i < NumWords; i++) begin
			next_m[i] = mask_q[i] && (off_q < WordLen[i])
				&& (word_char(i, off_q) == lc);
			first_m[i] = (WordText[i][0] == lc);
			if (next_m[i] && ({1'b0, off_q} + 5'd1 == {1'b0, WordLen[i]})) begin
				done_flags = done_flags | WordFlag[i];
			end
		end
		done_any = 1'b0;
		for (int i = 0; i < NumWords; i++) begin
			if (next_m[i] && ({1'b0, off_q} + 5'd1 == {1'b0, WordLen[i]})) begin
				done_any = 1'b1;
			end
		end
	end

	always_comb begin
		phase_d   = phase_q;
		off_d     = off_q;
		mask_d    = mask_q;
		flags_d   = flags_q;
		count_d   = count_q;
		pos_d     = pos_q;
		emit      = 1'b0;
		st        = ST_OK;
		tok_start = 1'b0;
		bump      = 1'b0;
		go_custom = 1'b0;
		if (start_s1) begin
			phase_d = PH_PREFIX;
			off_d   = '0;
			mask_d  = '0;
			flags_d = '0;
			count_d = '0;
			pos_d   = '0;
		end
		if (phase_d != PH_IDLE) begin
			if (pos_d < PosWidth'(MaxLength)) begin
				pos_d = pos_d + PosWidth'(1);
			end
			unique case (phase_d)
				PH_PREFIX: begin
					if (lc == head_char(off_d[2:0])) begin
						if (off_d == 4'd4) begin
							off_d   = '0;
							phase_d = PH_PAREN;
						end else begin
							off_d = off_d + 4'd1;
						end
					end else begin
						emit = 1'b1;
						st   = ST_NOT_FLAGS;
					end
				end
				PH_PAREN: begin
					if (is_ws(byte_s1)) begin
						phase_d = PH_PAREN;
					end else if (byte_s1 == "(") begin
						flags_d = '0;
						count_d = '0;
						phase_d = PH_FIRST;
					end else begin
						emit = 1'b1;
						st   = ST_NO_PAREN;
					end
				end
				PH_FIRST, PH_GAP: begin
					if (byte_s1 == 8'h00) begin
						emit = 1'b1;
						st   = ST_UNTERM;
					end else if (byte_s1 == ")") begin
						emit = 1'b1;
						st   = ST_OK;
					end else if (phase_d == PH_GAP && is_ws(byte_s1)) begin
						phase_d = PH_GAP;
					end else begin
						tok_start = 1'b1;
					end
				end
				PH_MATCH: begin
					if (next_m == '0) begin
						bump = 1'b1;
					end else if (done_any) begin
						flags_d = flags_d | done_flags;
						mask_d  = '0;
						off_d   = '0;
						phase_d = PH_GAP;
					end else begin
						mask_d = next_m;
						off_d  = off_d + 4'd1;
					end
				end
				PH_CUSTOM: begin
					go_custom = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
			if (tok_start) begin
				if (first_m == '0) begin
					bump = 1'b1;
				end else begin
					mask_d  = first_m;
					off_d   = 4'd1;
					phase_d = PH_MATCH;
				end
			end
			if (bump) begin
				if (count_d != 8'hFF) begin
					count_d = count_d + 8'd1;
				end
				mask_d    = '0;
				off_d     = '0;
				go_custom = 1'b1;
			end
			if (go_custom) begin
				if (byte_s1 == 8'h00) begin
					emit = 1'b1;
					st   = ST_UNTERM;
				end else if (byte_s1 == ")") begin
					emit = 1'b1;
					st   = ST_OK;
				end else if (is_ws(byte_s1)) begin
					phase_d = PH_GAP;
				end else begin
					phase_d = PH_CUSTOM;
				end
			end
			if (emit) begin
				phase_d = PH_IDLE;
				mask_d  = '0;
				off_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			off_q   <= '0;
			mask_q  <= '0;
			flags_q <= '0;
			count_q <= '0;
			pos_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			off_q   <= off_d;
			mask_q  <= mask_d;
			flags_q <= flags_d;
			count_q <= count_d;
			pos_q   <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_proc) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			status_q    <= st;
			flags_out_q <= (st == ST_OK || st == ST_UNTERM) ? flags_d : 5'd0;
			count_out_q <= (st == ST_OK || st == ST_UNTERM) ? count_d : 8'd0;
			len_out_q   <= (st == ST_OK) ? pos_d : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign deleted_flag    = flags_out_q[0];
	assign flagged_flag    = flags_out_q[1];
	assign answered_flag   = flags_out_q[2];
	assign seen_flag       = flags_out_q[3];
	assign old_flag        = flags_out_q[4];
	assign keyword_count   = count_out_q;
	assign consumed_length = len_out_q;

`ifndef SYNTH
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosWidth'(MaxLength))
		else $error("byte position past limit");

	a_len_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_OK) |-> len_out_q == '0)
		else $error("length reported on failed string");

	a_prefix_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_NOT_FLAGS || status_q == ST_NO_PAREN)
			|-> flags_out_q == 5'd0 && count_out_q == 8'd0)
		else $error("flags or count reported without list");

	a_start_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && starts_string |=> valid_s1 && start_s1)
		else $error("string start lost in input register");

	a_emit_idles: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> phase_q == PH_IDLE)
		else $error("parser not idle after result");
`endif

endmodule

`default_nettype wire

### tb/tb_imap_flags_list_parser.sv
`timescale 1ns / 1ps

module tb_imap_flags_list_parser;
	import ifp_pkg::*;

	typedef struct {
		logic       starts;
		logic [7:0] data;
		int         gap;
		bit         drain;
	} beat_t;

	typedef struct {
		status_t             status;
		logic [4:0]          flags;
		logic [7:0]          count;
		logic [PosWidth-1:0] length;
	} summary_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                starts_string = 1'b0;
	logic [7:0]          text_byte = 8'h00;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          status;
	logic                deleted_flag;
	logic                flagged_flag;
	logic                answered_flag;
	logic                seen_flag;
	logic                old_flag;
	logic [7:0]          keyword_count;
	logic [PosWidth-1:0] consumed_length;

	string      known_word [6] = '{
		"\\deleted", "\\flagged", "\\answered", "\\seen", "\\recent", "old"
	};
	logic [4:0] flag_bit [6] = '{5'b00001, 5'b00010, 5'b00100, 5'b01000, 5'b00000, 5'b10000};
	string      head_word = "flags";

	beat_t      pending_bytes [$];
	summary_t   awaited_summaries [$];
	logic [7:0] line_buf [$];

	phase_t              pf_phase = PH_IDLE;
	logic [3:0]          pf_off = '0;
	logic [5:0]          pf_cand = '0;
	logic [4:0]          pf_flags = '0;
	logic [7:0]          pf_kw = '0;
	logic [PosWidth-1:0] pf_pos = '0;

	bit tx_calm = 1'b0;
	bit hold_next = 1'b0;
	bit in_taken = 1'b0;
	bit rx_drawn = 1'b0;
	int tx_idle = 0;
	int rx_left = 0;
	int rx_calm_left = 0;
	int counted_beats = 0;
	int mismatch_count = 0;

	imap_flags_list_parser i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.starts_string   (starts_string),
		.text_byte       (text_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.deleted_flag    (deleted_flag),
		.flagged_flag    (flagged_flag),
		.answered_flag   (answered_flag),
		.seen_flag       (seen_flag),
		.old_flag        (old_flag),
		.keyword_count   (keyword_count),
		.consumed_length (consumed_length)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) ? (c ^ 8'h20) : c;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	task automatic close_string(input status_t s);
		summary_t r;
		bit       listed;
		listed = (s == ST_OK || s == ST_UNTERM);
		r.status = s;
		r.flags = listed ? pf_flags : 5'b0;
		r.count = listed ? pf_kw : 8'd0;
		r.length = (s == ST_OK) ? pf_pos : '0;
		awaited_summaries.push_back(r);
		pf_phase = PH_IDLE;
		pf_cand = '0;
		pf_off = '0;
	endtask

	task automatic keyword_char(input logic [7:0] c);
		if (c == 8'h00) begin
			close_string(ST_UNTERM);
		end else if (c == ")") begin
			close_string(ST_OK);
		end else if (is_blank(c)) begin
			pf_phase = PH_GAP;
		end else begin
			pf_phase = PH_CUSTOM;
		end
	endtask

	task automatic keyword_open(input logic [7:0] c);
		if (pf_kw != 8'hff) begin
			pf_kw = pf_kw + 8'd1;
		end
		pf_cand = '0;
		pf_off = '0;
		keyword_char(c);
	endtask

	task automatic token_begin(input logic [7:0] c);
		logic [5:0] hits;
		hits = '0;
		for (int i = 0; i < 6; i++) begin
			if (known_word[i][0] == fold_case(c)) begin
				hits[i] = 1'b1;
			end
		end
		if (hits == '0) begin
			keyword_open(c);
		end else begin
			pf_cand = hits;
			pf_off = 4'd1;
			pf_phase = PH_MATCH;
		end
	endtask

	task automatic advance_parse(input logic st, input logic [7:0] c);
		logic [5:0] hits;
		bit         done;
		hits = '0;
		done = 1'b0;
		if (st) begin
			pf_phase = PH_PREFIX;
			pf_off = '0;
			pf_cand = '0;
			pf_flags = '0;
			pf_kw = '0;
			pf_pos = '0;
		end
		if (pf_phase == PH_IDLE) begin
			return;
		end
		if (pf_pos < MaxLength) begin
			pf_pos = pf_pos + 1'b1;
		end
		case (pf_phase)
			PH_PREFIX: begin
				if (pf_off < 4'd5 && fold_case(c) == head_word[pf_off]) begin
					pf_off = pf_off + 4'd1;
					if (pf_off == 4'd5) begin
						pf_off = '0;
						pf_phase = PH_PAREN;
					end
				end else begin
					close_string(ST_NOT_FLAGS);
				end
			end
			PH_PAREN: begin
				if (!is_blank(c)) begin
					if (c == "(") begin
						pf_flags = '0;
						pf_kw = '0;
						pf_phase = PH_FIRST;
					end else begin
						close_string(ST_NO_PAREN);
					end
				end
			end
			PH_FIRST, PH_GAP: begin
				if (c == 8'h00) begin
					close_string(ST_UNTERM);
				end else if (c == ")") begin
					close_string(ST_OK);
				end else if (!(pf_phase == PH_GAP && is_blank(c))) begin
					token_begin(c);
				end
			end
			PH_MATCH: begin
				for (int i = 0; i < 6; i++) begin
					if (pf_cand[i] && pf_off < known_word[i].len()
					    && known_word[i][pf_off] == fold_case(c)) begin
						hits[i] = 1'b1;
					end
				end
				if (hits == '0) begin
					keyword_open(c);
				end else begin
					for (int i = 0; i < 6; i++) begin
						if (!done && hits[i] && pf_off + 1 == known_word[i].len()) begin
							pf_flags = pf_flags | flag_bit[i];
							pf_cand = '0;
							pf_off = '0;
							pf_phase = PH_GAP;
							done = 1'b1;
						end
					end
					if (!done) begin
						pf_cand = hits;
						pf_off = pf_off + 4'd1;
					end
				end
			end
			PH_CUSTOM: begin
				keyword_char(c);
			end
			default: begin
				pf_phase = PH_IDLE;
			end
		endcase
	endtask

	task automatic queue_beat(input logic st, input logic [7:0] b, input bit counted);
		beat_t bt;
		bt.starts = st;
		bt.data = b;
		bt.gap = tx_calm ? 0 : int'($urandom_range(0, 3));
		bt.drain = hold_next;
		hold_next = 1'b0;
		pending_bytes.push_back(bt);
		if (counted) begin
			counted_beats++;
		end
	endtask

	task automatic add_text(input string s, input bit mix);
		logic [7:0] ch;
		for (int k = 0; k < s.len(); k++) begin
			ch = s[k];
			if (mix && ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) begin
				ch = ch - 8'd32;
			end
			line_buf.push_back(ch);
		end
	endtask

	task automatic add_blank();
		int pick;
		pick = $urandom_range(0, 5);
		line_buf.push_back(pick == 5 ? 8'h20 : 8'(9 + pick));
	endtask

	task automatic flush_line(input bit counted);
		for (int k = 0; k < line_buf.size(); k++) begin
			queue_beat(k == 0, line_buf[k], counted);
		end
		line_buf.delete();
	endtask

	task automatic build_list_line();
		int         n;
		int         pick;
		int         len;
		int         ending;
		logic [7:0] ch;
		string      w;
		add_text("flags", 1'b1);
		if ($urandom_range(0, 9) == 0) begin
			line_buf[$urandom_range(0, 4)] = 8'($urandom);
		end
		repeat ($urandom_range(0, 2)) add_blank();
		if ($urandom_range(0, 11) == 0) begin
			line_buf.push_back(8'($urandom));
		end else begin
			line_buf.push_back("(");
		end
		n = $urandom_range(0, 6);
		for (int k = 0; k < n; k++) begin
			if (k == 0) begin
				if ($urandom_range(0, 5) == 0) begin
					add_blank();
				end
			end else if ($urandom_range(0, 5) != 0) begin
				repeat ($urandom_range(1, 2)) add_blank();
			end
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				w = known_word[pick];
				if ($urandom_range(0, 4) == 0) begin
					len = $urandom_range(1, w.len() - 1);
					add_text(w.substr(0, len - 1), 1'b1);
					line_buf.push_back(8'($urandom_range(33, 126)));
				end else begin
					add_text(w, 1'b1);
				end
			end else begin
				len = $urandom_range(1, 5);
				for (int j = 0; j < len; j++) begin
					do begin
						ch = 8'($urandom_range(1, 255));
					end while (is_blank(ch) || ch == ")");
					line_buf.push_back(ch);
				end
			end
		end
		ending = $urandom_range(0, 49);
		if (ending < 40 || ending >= 46) begin
			line_buf.push_back(")");
		end else if (ending < 44) begin
			line_buf.push_back(8'h00);
		end
		flush_line(1'b1);
		if (ending >= 46) begin
			repeat ($urandom_range(1, 4)) queue_beat(1'b0, 8'($urandom), 1'b0);
		end
	endtask

	task automatic build_noise_line();
		if ($urandom_range(0, 1) == 1) begin
			add_text("FLAGS (", 1'b1);
		end
		repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom));
		if ($urandom_range(0, 1) == 1) begin
			line_buf.push_back(")");
		end
		flush_line(1'b1);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_bytes.size() != 0 && tx_idle >= pending_bytes[0].gap
				    && !(pending_bytes[0].drain && awaited_summaries.size() != 0)) begin
					in_valid <= 1'b1;
					starts_string <= pending_bytes[0].starts;
					text_byte <= pending_bytes[0].data;
					void'(pending_bytes.pop_front());
					tx_idle = 0;
				end else begin
					in_valid <= 1'b0;
					tx_idle = tx_idle + 1;
				end
			end
			if (out_valid && !rx_drawn) begin
				rx_drawn = 1'b1;
				if (rx_calm_left > 0) begin
					rx_calm_left--;
					rx_left = 0;
				end else begin
					rx_left = $urandom_range(0, 3);
					if ($urandom_range(0, 7) == 0) begin
						rx_calm_left = 12;
					end
				end
			end
			if (rx_left > 0) begin
				out_stall <= 1'b1;
				rx_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_ports
		summary_t   want;
		logic [4:0] got_flags;
		in_taken = in_valid && !in_stall;
		if (arst_n && in_taken) begin
			advance_parse(starts_string, text_byte);
		end
		if (arst_n && out_valid && !out_stall) begin
			rx_drawn = 1'b0;
			got_flags = {old_flag, seen_flag, answered_flag, flagged_flag, deleted_flag};
			if (awaited_summaries.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: unexpected beat: st=%0d flags=%b kw=%0d len=%0d",
						$realtime, status, got_flags, keyword_count, consumed_length);
				end
			end else begin
				want = awaited_summaries.pop_front();
				if (status != want.status || got_flags != want.flags
				    || keyword_count != want.count || consumed_length != want.length) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: exp st=%0d fl=%b kw=%0d len=%0d, got st=%0d fl=%b kw=%0d len=%0d",
							$realtime, want.status, want.flags, want.count, want.length,
							status, got_flags, keyword_count, consumed_length);
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int idx;
		int sat_at;

		queue_beat(1'b0, "z", 1'b0);
		add_text("FLAGS (\\Deleted \\FLAGGED \\answered \\Seen \\Recent Old)", 1'b0);
		flush_line(1'b1);
		add_text("flags()", 1'b0);
		flush_line(1'b1);
		add_text("FLAGS( foo)", 1'b0);
		flush_line(1'b1);
		add_text("FLAGX (", 1'b0);
		flush_line(1'b1);
		add_text("FLAGS  x", 1'b0);
		flush_line(1'b1);
		add_text("FLAGS (\\seen", 1'b0);
		line_buf.push_back(8'h00);
		flush_line(1'b1);
		queue_beat(1'b0, "q", 1'b0);
		queue_beat(1'b0, "(", 1'b0);
		add_text("FLAGS (\\delxx $Junk)", 1'b0);
		flush_line(1'b1);
		add_text("FLAGS (\\seen\\deleted)", 1'b0);
		flush_line(1'b1);
		add_text("FLAGS (\\se", 1'b0);
		flush_line(1'b1);
		add_text("Flags(old \\RECENT)", 1'b0);
		flush_line(1'b1);
		add_text("FLAGS", 1'b0);
		for (int k = 9; k <= 13; k++) begin
			line_buf.push_back(8'(k));
		end
		line_buf.push_back(8'h20);
		line_buf.push_back("(");
		line_buf.push_back(8'hff);
		line_buf.push_back(8'h80);
		line_buf.push_back(8'h7f);
		line_buf.push_back(")");
		flush_line(1'b1);
		line_buf.push_back(8'h00);
		flush_line(1'b1);

		counted_beats = 0;
		sat_at = $urandom_range(5, 35);
		for (idx = 0; counted_beats < 450 || idx < 40; idx++) begin
			tx_calm = ($urandom_range(0, 5) == 0);
			if (idx == 20 || $urandom_range(0, 24) == 0) begin
				hold_next = 1'b1;
			end
			if (idx == sat_at) begin
				add_text("FLAGS (", 1'b0);
				repeat (300) begin
					line_buf.push_back("k");
					add_blank();
				end
				line_buf.push_back(")");
				flush_line(1'b0);
				add_text("flags (", 1'b0);
				repeat (4100) add_blank();
				add_text("\\seen)", 1'b0);
				flush_line(1'b0);
			end
			if ($urandom_range(0, 9) == 0) begin
				build_noise_line();
			end else begin
				build_list_line();
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || in_valid) @(negedge clk);
		while (awaited_summaries.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && awaited_summaries.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
